@@ sv/wbz_pkg.sv @@
// ----------------------------------------------------------------------------
// Welford baseline package
// Shared types, codes and constants of the running mean/variance z-score block.
// ----------------------------------------------------------------------------
package wbz_pkg;

  // Field widths fixed by the item format.
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 4;
  localparam int OP_W      = 2;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_ZSCORE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_PER_DAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_DAYS      = 1'd1;

  localparam logic [CFG_W-1:0] WPD_RESET   = 16'd1440;
  localparam logic [CFG_W-1:0] CALIB_RESET = 16'd7;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_U_DIV,
    ST_U_DIVW,
    ST_U_MAG,
    ST_U_MUL,
    ST_U_WB,
    ST_Z_VAR,
    ST_Z_VARW,
    ST_Z_SQ,
    ST_Z_SQW,
    ST_Z_DIV,
    ST_Z_DIVW,
    ST_DONE
  } wbz_state_t;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } wbz_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } wbz_div_rsp_t;

  // Square root request and response.
  typedef struct packed {
    logic        start;
    logic [63:0] value;
  } wbz_sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } wbz_sqrt_rsp_t;

  // Magnitude of a 34-bit signed value that stays within +/- 2^32.
  function automatic logic [32:0] mag34(input logic [33:0] v);
    logic [33:0] n;
    n = 34'd0 - v;
    return v[33] ? n[32:0] : v[32:0];
  endfunction

endpackage

@@ sv/wbz_if.sv @@
// ----------------------------------------------------------------------------
// Welford baseline channels
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface wbz_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [3:0]  feature_index;
  logic [31:0] feature_value;
  logic        value_missing;

  modport source (output valid, op, feature_index, feature_value, value_missing,
                  input ready);
  modport sink (input valid, op, feature_index, feature_value, value_missing,
                output ready);
endinterface

interface wbz_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] z_score;
  logic        z_present;
  logic        baseline_valid;
  logic [31:0] window_count;

  modport source (output valid, z_score, z_present, baseline_valid, window_count,
                  input ready);
  modport sink (input valid, z_score, z_present, baseline_valid, window_count,
                output ready);
endinterface

interface wbz_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/welford_baseline_zscore_core.sv @@
// ----------------------------------------------------------------------------
// Welford baseline z-score core
// Per-feature running mean and squared deviation sum with z-score requests.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result beat for each.
// An update runs a 64-step bit-serial division of the deviation by the
// window count, then a 33-step shift-add product. A z-score request runs a
// 64-step division of the squared deviation sum by n-1, a 32-step square
// root and a second 64-step division. The divider is shared and produces
// one quotient bit per cycle. Clear items, skipped updates and z-score
// requests that fail the accept checks go straight from idle to done. A new
// item is taken while the previous result still waits in the output
// register. The store's valid bits clear at reset or on a clear item.
module welford_baseline_zscore_core #(
  parameter int NUM_FEATURES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  wbz_in_if.sink     in_ch,
  wbz_out_if.source  out_ch,
  wbz_cfg_if.sink    cfg_ch
);
  import wbz_pkg::*;

  localparam int AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

  // Sequencer.
  wbz_state_t state_r, state_nxt;

  // Registers and counters.
  logic [CFG_W-1:0] wpd_r;
  logic [CFG_W-1:0] calib_r;
  logic [31:0]      ws_r;
  logic [15:0]      wid_r;
  logic [15:0]      days_r;
  logic             vflag_r;

  // Store.
  logic [31:0]             mean_mem [NUM_FEATURES];
  logic [63:0]             m2_mem   [NUM_FEATURES];
  logic [NUM_FEATURES-1:0] entry_vld_r;

  // Item and working registers.
  logic [AW-1:0] addr_r;
  logic [31:0]   x_r;
  logic          miss_r;
  logic          op_is_upd_r;
  logic [31:0]   mean_rd_r;
  logic [63:0]   m2_rd_r;
  logic          vld_rd_r;
  logic [31:0]   mean_r;
  logic [63:0]   m2_r;
  logic [33:0]   d_r;
  logic [31:0]   nm_r;
  logic [65:0]   mcand_r;
  logic [32:0]   mplier_r;
  logic [65:0]   acc_r;
  logic [5:0]    mul_cnt_r;
  logic [31:0]   z_r;
  logic          zp_r;

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_z_r;
  logic        out_zp_r;
  logic        out_bv_r;
  logic [31:0] out_wc_r;

  // Arithmetic units.
  wbz_div_req_t  div_req;
  wbz_div_rsp_t  div_rsp;
  wbz_sqrt_req_t sqrt_req;
  wbz_sqrt_rsp_t sqrt_rsp;

  wbz_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  wbz_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // Accept-time decode.
  logic          in_fire;
  logic          out_free;
  logic          start_win;
  logic          in_range;
  logic [31:0]   ws_inc;
  logic [31:0]   ws_after;
  logic [16:0]   wid_next;
  logic          day_done;
  logic [15:0]   days_inc;
  logic          go_upd;
  logic          go_z;
  logic [AW-1:0] in_addr;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign start_win = (in_ch.op == OP_UPDATE) && (in_ch.feature_index == 4'd0);
  assign in_range  = (32'(in_ch.feature_index) < 32'(NUM_FEATURES));
  assign in_addr   = AW'(in_ch.feature_index);
  assign ws_inc    = (ws_r == 32'hFFFF_FFFF) ? ws_r : ws_r + 32'd1;
  assign ws_after  = start_win ? ws_inc : ws_r;
  assign wid_next  = {1'b0, wid_r} + 17'd1;
  assign day_done  = (wid_next >= {1'b0, wpd_r});
  assign days_inc  = (days_r == 16'hFFFF) ? days_r : days_r + 16'd1;
  assign go_upd    = (in_ch.op == OP_UPDATE) && !in_ch.value_missing && in_range &&
                     (ws_after != 32'd0);
  assign go_z      = (in_ch.op == OP_ZSCORE) && vflag_r && (ws_r >= 32'd2) && in_range;

  // Datapath helpers.
  logic [32:0] d_mag;
  logic [32:0] q_lo;
  logic [33:0] nm_sum;
  logic [32:0] b_mag;
  logic [63:0] prod_sat;
  logic [64:0] m2_sum;
  logic [63:0] m2_new;
  logic [63:0] zq;
  logic [31:0] z_sat;

  assign d_mag    = mag34(d_r);
  assign q_lo     = div_rsp.quotient[32:0];
  assign nm_sum   = {{2{mean_r[31]}}, mean_r} + (d_r[33] ? (34'd0 - {1'b0, q_lo})
                                                          : {1'b0, q_lo});
  assign b_mag    = mag34({{2{x_r[31]}}, x_r} - {{2{nm_r[31]}}, nm_r});
  assign prod_sat = (acc_r[65:64] != 2'b00) ? 64'hFFFF_FFFF_FFFF_FFFF : acc_r[63:0];
  assign m2_sum   = {1'b0, m2_r} + {1'b0, prod_sat};
  assign m2_new   = m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
  assign zq       = div_rsp.quotient;

  // Saturate the quotient into the signed result range.
  always_comb begin
    if (!d_r[33]) begin
      z_sat = (zq > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : zq[31:0];
    end else if (zq >= 64'h8000_0000) begin
      z_sat = 32'h8000_0000;
    end else begin
      z_sat = 32'd0 - zq[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (go_upd || go_z) ? ST_READ : ST_DONE;
        end
      end
      ST_READ:   state_nxt = (op_is_upd_r) ? ST_U_DIV : ST_Z_VAR;
      ST_U_DIV:  state_nxt = ST_U_DIVW;
      ST_U_DIVW: state_nxt = div_rsp.done ? ST_U_MAG : ST_U_DIVW;
      ST_U_MAG:  state_nxt = ST_U_MUL;
      ST_U_MUL:  state_nxt = (mul_cnt_r == 6'd32) ? ST_U_WB : ST_U_MUL;
      ST_U_WB:   state_nxt = ST_DONE;
      ST_Z_VAR:  state_nxt = ST_Z_VARW;
      ST_Z_VARW: state_nxt = div_rsp.done ? ST_Z_SQ : ST_Z_VARW;
      ST_Z_SQ:   state_nxt = ST_Z_SQW;
      ST_Z_SQW: begin
        if (sqrt_rsp.done) begin
          state_nxt = ((sqrt_rsp.root == 32'd0) || miss_r) ? ST_DONE : ST_Z_DIV;
        end
      end
      ST_Z_DIV:  state_nxt = ST_Z_DIVW;
      ST_Z_DIVW: state_nxt = div_rsp.done ? ST_DONE : ST_Z_DIVW;
      ST_DONE:   state_nxt = out_free ? ST_IDLE : ST_DONE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ch.ready       = (state_r == ST_IDLE);
    div_req.start     = 1'b0;
    div_req.dividend  = {31'd0, d_mag};
    div_req.divisor   = ws_r;
    sqrt_req.start    = (state_r == ST_Z_SQ);
    sqrt_req.value    = div_rsp.quotient;
    case (state_r)
      ST_U_DIV: begin
        div_req.start = 1'b1;
      end
      ST_Z_VAR: begin
        div_req.start    = 1'b1;
        div_req.dividend = m2_r;
        div_req.divisor  = ws_r - 32'd1;
      end
      ST_Z_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {15'd0, d_mag, 16'd0};
        div_req.divisor  = sqrt_rsp.root;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Control state, counters and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wpd_r       <= WPD_RESET;
      calib_r     <= CALIB_RESET;
      ws_r        <= '0;
      wid_r       <= '0;
      days_r      <= '0;
      vflag_r     <= 1'b0;
      entry_vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes.
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_WINDOWS_PER_DAY: wpd_r   <= cfg_ch.data;
          CFG_CALIB_DAYS:      calib_r <= cfg_ch.data;
          default: begin
          end
        endcase
      end

      // Window and day counting, or clearing the store.
      if (in_fire) begin
        if (in_ch.op == OP_CLEAR) begin
          ws_r        <= '0;
          wid_r       <= '0;
          days_r      <= '0;
          vflag_r     <= 1'b0;
          entry_vld_r <= '0;
        end else if (start_win) begin
          ws_r <= ws_inc;
          if (day_done) begin
            wid_r  <= '0;
            days_r <= days_inc;
            if (days_inc >= calib_r) begin
              vflag_r <= 1'b1;
            end
          end else begin
            wid_r <= wid_next[15:0];
          end
        end
      end

      if (state_r == ST_U_WB) begin
        entry_vld_r[addr_r] <= 1'b1;
      end

      // Output beat handshake.
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (state_r == ST_U_WB) begin
      mean_mem[addr_r] <= nm_r;
      m2_mem[addr_r]   <= m2_new;
    end
    if (in_fire) begin
      mean_rd_r <= mean_mem[in_addr];
      m2_rd_r   <= m2_mem[in_addr];
      vld_rd_r  <= entry_vld_r[in_addr];
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r      <= in_addr;
      x_r         <= in_ch.feature_value;
      miss_r      <= in_ch.value_missing;
      op_is_upd_r <= (in_ch.op == OP_UPDATE);
      z_r         <= '0;
      zp_r        <= 1'b0;
    end
    case (state_r)
      ST_READ: begin
        mean_r <= vld_rd_r ? mean_rd_r : 32'd0;
        m2_r   <= vld_rd_r ? m2_rd_r : 64'd0;
        d_r    <= {{2{x_r[31]}}, x_r} -
                  (vld_rd_r ? {{2{mean_rd_r[31]}}, mean_rd_r} : 34'd0);
      end
      ST_U_DIVW: begin
        if (div_rsp.done) begin
          nm_r <= nm_sum[31:0];
        end
      end
      ST_U_MAG: begin
        mcand_r   <= {33'd0, b_mag};
        mplier_r  <= d_mag;
        acc_r     <= '0;
        mul_cnt_r <= '0;
      end
      ST_U_MUL: begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r   <= {mcand_r[64:0], 1'b0};
        mplier_r  <= {1'b0, mplier_r[32:1]};
        mul_cnt_r <= mul_cnt_r + 6'd1;
      end
      ST_Z_SQW: begin
        if (sqrt_rsp.done && (sqrt_rsp.root == 32'd0)) begin
          zp_r <= 1'b1;
        end
      end
      ST_Z_DIVW: begin
        if (div_rsp.done) begin
          z_r  <= z_sat;
          zp_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_z_r  <= z_r;
      out_zp_r <= zp_r;
      out_bv_r <= vflag_r;
      out_wc_r <= ws_r;
    end
  end

  assign cfg_ch.ready          = 1'b1;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.z_score        = out_z_r;
  assign out_ch.z_present      = out_zp_r;
  assign out_ch.baseline_valid = out_bv_r;
  assign out_ch.window_count   = out_wc_r;

endmodule

@@ sv/wbz_div.sv @@
// ----------------------------------------------------------------------------
// Welford baseline divider
// Restoring 64-by-32 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wbz_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wbz_pkg::wbz_div_req_t req,
  output wbz_pkg::wbz_div_rsp_t rsp
);
  import wbz_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] num_r;
  logic [31:0] rem_r;
  logic [31:0] dsr_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // One trial subtraction per cycle.
  assign trial = {rem_r, num_r[63]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift registers: the dividend shifts out while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      num_r <= {num_r[62:0], ge};
      rem_r <= ge ? diff[31:0] : trial[31:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = num_r;

endmodule

@@ sv/wbz_sqrt.sv @@
// ----------------------------------------------------------------------------
// Welford baseline square root
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module wbz_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wbz_pkg::wbz_sqrt_req_t req,
  output wbz_pkg::wbz_sqrt_rsp_t rsp
);
  import wbz_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] val_r;
  logic [32:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [34:0] diff;
  logic        ge;

  // Bring down two bits and try the next root bit.
  assign rem_sh = {rem_r, val_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign ge     = (rem_sh >= trial);

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial root.
  always_ff @(posedge clk) begin
    if (req.start) begin
      val_r  <= req.value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= {val_r[61:0], 2'b00};
      rem_r  <= ge ? diff[32:0] : rem_sh[32:0];
      root_r <= {root_r[30:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule
